@@ design/iirdf1_pkg.sv @@
package iirdf1_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = 32;
    // Five products of at most 2^30 in magnitude fit in 34 signed bits.
    localparam int ACC_W    = 34;
    // Quotient bits formed by the divider; anything at or above 2^QUO_W saturates.
    localparam int QUO_W    = 17;
    localparam int STEP_W   = 4;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } out_item_t;

    localparam logic KIND_FILTER  = 1'b0;
    localparam logic KIND_PRELOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_NUM0 = 3'd0;
    localparam logic [2:0] REG_NUM1 = 3'd1;
    localparam logic [2:0] REG_NUM2 = 3'd2;
    localparam logic [2:0] REG_DEN0 = 3'd3;
    localparam logic [2:0] REG_DEN1 = 3'd4;
    localparam logic [2:0] REG_DEN2 = 3'd5;
    localparam logic [2:0] NUM_REGS = 3'd6;

    // Product selection: sample history tap times its coefficient.
    localparam logic [2:0] TAP_X0 = 3'd0;
    localparam logic [2:0] TAP_X1 = 3'd1;
    localparam logic [2:0] TAP_X2 = 3'd2;
    localparam logic [2:0] TAP_Y1 = 3'd3;
    localparam logic [2:0] TAP_Y2 = 3'd4;

    // Accumulator operations on the registered product.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // Sequencer branch codes.
    localparam logic [1:0] BR_NEXT   = 2'd0;
    localparam logic [1:0] BR_LOOP   = 2'd1;
    localparam logic [1:0] BR_FINISH = 2'd2;

    localparam logic [STEP_W-1:0] STEP_DIV = 4'd8;

    typedef struct packed {
        logic              mul_en;
        logic [2:0]        tap;
        logic [1:0]        acc_op;
        logic              make_num;
        logic              div_start;
        logic              div_step;
        logic              finish;
        logic [1:0]        br;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

    typedef struct packed {
        logic last;
        logic ovf;
    } div_stat_t;

    // The filter program. Each product is registered in the step before the one
    // that accumulates it, so the multiply of one tap overlaps the accumulate of the last.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            4'd0: begin
                w.mul_en = 1'b1; w.tap = TAP_X0;
            end
            4'd1: begin
                w.mul_en = 1'b1; w.tap = TAP_X1; w.acc_op = ACC_LOAD;
            end
            4'd2: begin
                w.mul_en = 1'b1; w.tap = TAP_X2; w.acc_op = ACC_ADD;
            end
            4'd3: begin
                w.mul_en = 1'b1; w.tap = TAP_Y1; w.acc_op = ACC_ADD;
            end
            4'd4: begin
                w.mul_en = 1'b1; w.tap = TAP_Y2; w.acc_op = ACC_SUB;
            end
            4'd5: begin
                w.acc_op = ACC_SUB;
            end
            4'd6: begin
                w.make_num = 1'b1;
            end
            4'd7: begin
                w.div_start = 1'b1;
            end
            STEP_DIV: begin
                w.div_step = 1'b1; w.br = BR_LOOP; w.target = STEP_DIV;
            end
            4'd9: begin
                w.finish = 1'b1; w.br = BR_FINISH;
            end
            default: begin
                w.br = BR_FINISH;
            end
        endcase
        return w;
    endfunction

endpackage

@@ design/iir_direct_form_one_filter.sv @@
// Channel   Direction  Signals                     Item contents
// input     in         s_valid s_ready s_data      kind, sample_in
// result    out        m_valid m_ready m_data      sample_out, saturated
// config    in         cfg_wr_en cfg_index cfg_data  coefficient writes, no wait
//
// A filter item runs from acceptance until its result is loaded into the output
// register through eight steps of multiply, accumulate and divider setup, then
// 17 steps of the restoring divider, then one finish step.
// A preload item is absorbed in the cycle it is accepted and gives no result.
// Reset (aresetn low at a clock edge) clears both histories and restores the
// coefficients to unity gain; the output register is emptied.
// A held result stalls only the finish step; the next item can be accepted in the
// cycle after the previous one has moved into the output register, so a new
// filter item is not taken while one is in work.
module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int NUM_TAPS = 3,
    parameter int DEN_TAPS = 3
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    // Tap counts as 4-bit values, compared against the tap positions.
    localparam logic [3:0] NUM_TAPS_L = 4'(NUM_TAPS);
    localparam logic [3:0] DEN_TAPS_L = 4'(DEN_TAPS);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Coefficient registers, each read at its own fixed place.
    logic signed [COEF_W-1:0] coef_reg [6];

    // Sequencer state.
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] pc_reg, pc_next;
    ucode_t            uw;

    // Sample histories, newest first.
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] xh0_reg, xh0_next, xh1_reg, xh1_next;
    logic signed [SAMPLE_W-1:0] yh0_reg, yh0_next, yh1_reg, yh1_next;

    // Datapath.
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [COEF_W-1:0]   op_b;
    logic                       tap_used;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    prod_ext;
    logic [ACC_W-1:0]           num_reg, num_next;
    logic [ACC_W-1:0]           half_ext;
    logic [15:0]                den_abs_reg, den_abs_next;
    logic                       s_neg_reg, s_neg_next;
    logic                       q_neg_reg, q_neg_next;
    logic                       dzero_reg, dzero_next;
    logic [15:0]                den_abs_c;

    // Divider link.
    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [QUO_W-1:0] quo;

    // Result.
    logic                       m_valid_reg, m_valid_next;
    out_item_t                  m_data_reg, m_data_next;
    logic signed [SAMPLE_W-1:0] y_c;
    logic                       sat_c;

    logic in_fire;
    logic out_free;
    logic fin_fire;

    assign s_ready  = !busy_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign uw       = ucode_rom(pc_reg);
    assign fin_fire = busy_reg && uw.finish && out_free;

    // Configuration writes; indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[REG_NUM0] <= 16'sd16384;
            coef_reg[REG_NUM1] <= '0;
            coef_reg[REG_NUM2] <= '0;
            coef_reg[REG_DEN0] <= 16'sd16384;
            coef_reg[REG_DEN1] <= '0;
            coef_reg[REG_DEN2] <= '0;
        end else if (cfg_wr_en && (cfg_index < NUM_REGS)) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Step counter with conditional jumps taken from the control word.
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg) begin
            if (in_fire && (s_data.kind == KIND_FILTER)) begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end else begin
            case (uw.br)
                BR_NEXT: begin
                    pc_next = pc_reg + STEP_W'(1);
                end
                BR_LOOP: begin
                    pc_next = div_stat.last ? pc_reg + STEP_W'(1) : uw.target;
                end
                BR_FINISH: begin
                    if (out_free) begin
                        busy_next = 1'b0;
                        pc_next   = '0;
                    end
                end
                default: begin
                    pc_next = pc_reg + STEP_W'(1);
                end
            endcase
        end
    end

    // Operand selection for the single multiplier. Taps beyond the configured
    // orders contribute nothing.
    always_comb begin
        op_a     = x_reg;
        op_b     = coef_reg[REG_NUM0];
        tap_used = 1'b0;
        case (uw.tap)
            TAP_X0: begin
                op_a = x_reg;   op_b = coef_reg[REG_NUM0];
                tap_used = (4'd0 < NUM_TAPS_L);
            end
            TAP_X1: begin
                op_a = xh0_reg; op_b = coef_reg[REG_NUM1];
                tap_used = (4'd1 < NUM_TAPS_L);
            end
            TAP_X2: begin
                op_a = xh1_reg; op_b = coef_reg[REG_NUM2];
                tap_used = (4'd2 < NUM_TAPS_L);
            end
            TAP_Y1: begin
                op_a = yh0_reg; op_b = coef_reg[REG_DEN1];
                tap_used = (4'd1 < DEN_TAPS_L);
            end
            TAP_Y2: begin
                op_a = yh1_reg; op_b = coef_reg[REG_DEN2];
                tap_used = (4'd2 < DEN_TAPS_L);
            end
            default: begin
                tap_used = 1'b0;
            end
        endcase
    end

    assign prod_full = op_a * op_b;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Magnitude of the divisor; the most negative code maps to 32768.
    assign den_abs_c = coef_reg[REG_DEN0][15] ? 16'(-coef_reg[REG_DEN0])
                                              : coef_reg[REG_DEN0];
    assign half_ext  = ACC_W'(den_abs_c[15:1]);

    always_comb begin
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        den_abs_next = den_abs_reg;
        s_neg_next   = s_neg_reg;
        q_neg_next   = q_neg_reg;
        dzero_next   = dzero_reg;
        if (busy_reg && uw.mul_en) begin
            prod_next = tap_used ? prod_full : '0;
        end
        if (busy_reg) begin
            case (uw.acc_op)
                ACC_HOLD: acc_next = acc_reg;
                ACC_LOAD: acc_next = prod_ext;
                ACC_ADD:  acc_next = acc_reg + prod_ext;
                ACC_SUB:  acc_next = acc_reg - prod_ext;
                default:  acc_next = acc_reg;
            endcase
        end
        // Rounded magnitude numerator |S| + |d|/2.
        if (busy_reg && uw.make_num) begin
            num_next     = acc_reg[ACC_W-1] ? half_ext - ACC_W'(acc_reg)
                                            : ACC_W'(acc_reg) + half_ext;
            den_abs_next = den_abs_c;
            s_neg_next   = acc_reg[ACC_W-1];
            q_neg_next   = acc_reg[ACC_W-1] ^ coef_reg[REG_DEN0][15];
            dzero_next   = (coef_reg[REG_DEN0] == '0);
        end
    end

    assign div_ctrl.start = busy_reg && uw.div_start;
    assign div_ctrl.step  = busy_reg && uw.div_step;

    iirdf1_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .num     (num_reg),
        .den     (den_abs_reg),
        .quo     (quo),
        .stat    (div_stat)
    );

    // Sign restore and saturation of the rounded quotient.
    always_comb begin
        y_c   = SAMPLE_W'(quo);
        sat_c = 1'b0;
        if (dzero_reg) begin
            y_c   = s_neg_reg ? SAMPLE_MIN : SAMPLE_MAX;
            sat_c = 1'b1;
        end else if (div_stat.ovf) begin
            y_c   = q_neg_reg ? SAMPLE_MIN : SAMPLE_MAX;
            sat_c = 1'b1;
        end else if (q_neg_reg) begin
            if (quo > QUO_W'(32768)) begin
                y_c   = SAMPLE_MIN;
                sat_c = 1'b1;
            end else begin
                y_c = SAMPLE_W'(-quo);
            end
        end else begin
            if (quo > QUO_W'(32767)) begin
                y_c   = SAMPLE_MAX;
                sat_c = 1'b1;
            end else begin
                y_c = SAMPLE_W'(quo);
            end
        end
    end

    // Histories move on every filter result; a preload fills them all.
    always_comb begin
        x_next   = x_reg;
        xh0_next = xh0_reg;
        xh1_next = xh1_reg;
        yh0_next = yh0_reg;
        yh1_next = yh1_reg;
        if (in_fire) begin
            x_next = s_data.sample_in;
            if (s_data.kind == KIND_PRELOAD) begin
                xh0_next = s_data.sample_in;
                xh1_next = s_data.sample_in;
                yh0_next = s_data.sample_in;
                yh1_next = s_data.sample_in;
            end
        end else if (fin_fire) begin
            xh1_next = xh0_reg;
            xh0_next = x_reg;
            yh1_next = yh0_reg;
            yh0_next = y_c;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fin_fire) begin
            m_valid_next           = 1'b1;
            m_data_next.sample_out = y_c;
            m_data_next.saturated  = sat_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
            xh0_reg     <= '0;
            xh1_reg     <= '0;
            yh0_reg     <= '0;
            yh1_reg     <= '0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            xh0_reg     <= xh0_next;
            xh1_reg     <= xh1_next;
            yh0_reg     <= yh0_next;
            yh1_reg     <= yh1_next;
        end
        x_reg       <= x_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        den_abs_reg <= den_abs_next;
        s_neg_reg   <= s_neg_next;
        q_neg_reg   <= q_neg_next;
        dzero_reg   <= dzero_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // A result only appears after the finish step of the program.
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg && uw.finish))
        else $error("result appeared without a finish step");

    // An accepted filter item always starts the sequencer.
    a_filter_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_data.kind == KIND_FILTER)) |=> busy_reg)
        else $error("filter item did not start the sequencer");

    // While a filter item is in work, the histories change only at its finish.
    a_history_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !fin_fire) |=> ($stable(yh0_reg) && $stable(xh0_reg)))
        else $error("history changed during a filter item");

    // A flagged result is one of the two clip values.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.saturated) |->
        ((m_data_reg.sample_out == SAMPLE_MAX) || (m_data_reg.sample_out == SAMPLE_MIN)))
        else $error("saturated result is not a clip value");
`endif

endmodule

@@ design/iirdf1_divider.sv @@
module iirdf1_divider
    import iirdf1_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctrl_t        ctrl,
    input  logic [ACC_W-1:0] num,
    input  logic [15:0]      den,
    output logic [QUO_W-1:0] quo,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      rem_reg, rem_next;
    logic [QUO_W-1:0] work_reg, work_next;
    logic             ovf_reg, ovf_next;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             ge;

    // Restoring division, one quotient bit per step. The numerator's low bits
    // shift out of the work register as quotient bits shift in.
    always_comb begin
        trial = {rem_reg, work_reg[QUO_W-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
    end

    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        ovf_next  = ovf_reg;
        if (ctrl.start) begin
            // The quotient reaches 2^QUO_W exactly when the high part is not below den.
            ovf_next  = (num[ACC_W-1:QUO_W] >= {1'b0, den});
            rem_next  = num[QUO_W+15:QUO_W];
            work_next = num[QUO_W-1:0];
            cnt_next  = CNT_W'(QUO_W);
        end else if (ctrl.step) begin
            rem_next  = ge ? diff[15:0] : trial[15:0];
            work_next = {work_reg[QUO_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg  <= rem_next;
        work_reg <= work_next;
        ovf_reg  <= ovf_next;
    end

    assign quo       = work_reg;
    assign stat.last = (cnt_reg == CNT_W'(1));
    assign stat.ovf  = ovf_reg;

endmodule
